### src/rmst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_pkg
// Shared types and constants of the range-minimum segment tree.
// ----------------------------------------------------------------------------
package rmst_pkg;

   // leaf spans are held at the width of the leaves-in-use register
   localparam int SPAN_W      = 11;
   // levels of the deepest tree that a SPAN_W-bit leaf count can form
   localparam int TREE_LEVELS = SPAN_W + 1;
   localparam int SP_W        = $clog2(TREE_LEVELS + 1);

   localparam int FUNC_W      = 2;
   localparam int POS_W       = 10;
   localparam int DATA_W      = 16;
   localparam int CSR_IDX_W   = 1;

   // register reset values
   localparam logic [SPAN_W-1:0] LEAVES_RESET   = 11'd1024;
   localparam logic [DATA_W-1:0] SENTINEL_RESET = 16'hFFFF;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_LEAVES   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SENTINEL = 1'b1;

   // operation codes; the fourth code does nothing
   typedef enum logic [FUNC_W-1:0] {
      FUNC_QUERY  = 2'd0,
      FUNC_UPDATE = 2'd1,
      FUNC_CLEAR  = 2'd2
   } func_type;

   typedef struct packed {
      func_type          func;
      logic [POS_W-1:0]  leaf_position;
      logic [DATA_W-1:0] leaf_value;
      logic [POS_W-1:0]  range_low;
      logic [POS_W-1:0]  range_high;
   } req_item_type;

   typedef struct packed {
      logic ready;   // sequencer can take an item
      logic done;    // result waiting in the sequencer
   } seq_status_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_QWALK,
      ST_QDRAIN,
      ST_UDOWN,
      ST_URD,
      ST_UWR,
      ST_FINISH
   } seq_state_type;

endpackage

### src/rmst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmst_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

### src/rmst_min_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_min_unit
// Shared unsigned compare-and-select unit used by queries and updates.
// ----------------------------------------------------------------------------
module rmst_min_unit #(
   parameter int WIDTH = 16
) (
   input  logic [WIDTH-1:0] a,
   input  logic [WIDTH-1:0] b,
   output logic [WIDTH-1:0] y
);

   // smaller of the two; ties keep a
   assign y = (b < a) ? b : a;

endmodule

### src/rmst_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmst_seq
// Sequencer that walks the tree node by node: clearing sweep, query
// descent with a stack of pending right children, update descent and ascent.
// ----------------------------------------------------------------------------
module rmst_seq #(
   parameter int LEAF_COUNT = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    start,
   input  rmst_pkg::req_item_type                  item,
   input  logic [rmst_pkg::SPAN_W-1:0]             size,
   input  logic [VALUE_BITS-1:0]                   sentinel,
   input  logic                                    out_free,
   output rmst_pkg::seq_status_type                status,
   output logic [VALUE_BITS-1:0]                   result,
   output logic                                    ram_we,
   output logic [$clog2(2*LEAF_COUNT)-1:0]         ram_waddr,
   output logic [VALUE_BITS-1:0]                   ram_wdata,
   output logic [$clog2(2*LEAF_COUNT)-1:0]         ram_raddr,
   input  logic [VALUE_BITS-1:0]                   ram_rdata
);

   localparam int NODE_SLOTS = 2 * LEAF_COUNT;
   localparam int ADDR_W     = $clog2(NODE_SLOTS);
   localparam int NODE_W     = $clog2(LEAF_COUNT) + 2;
   localparam int SPAN_W     = rmst_pkg::SPAN_W;
   localparam int SP_W       = rmst_pkg::SP_W;

   localparam logic [NODE_W-1:0] ROOT      = NODE_W'(1);
   localparam logic [NODE_W-1:0] SLOT_LIM  = NODE_W'(NODE_SLOTS);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NODE_SLOTS - 1);

   rmst_pkg::seq_state_type state_ff, state_in;

   logic [SPAN_W-1:0]     pos_ff, pos_in;
   logic [VALUE_BITS-1:0] val_ff, val_in;
   logic [SPAN_W-1:0]     lo_ff, lo_in;
   logic [SPAN_W-1:0]     hi_ff, hi_in;
   logic [NODE_W-1:0]     k_ff, k_in;
   logic [SPAN_W-1:0]     l_ff, l_in;
   logic [SPAN_W-1:0]     r_ff, r_in;
   logic [VALUE_BITS-1:0] acc_ff, acc_in;
   logic                  pend_ff, pend_in;
   logic                  opnd_sent_ff, opnd_sent_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  clr_op_ff, clr_op_in;
   logic [VALUE_BITS-1:0] fill_ff, fill_in;
   logic [SP_W-1:0]       sp_ff, sp_in;

   // stack of pending right children
   logic [NODE_W-1:0]     stk_k_ff [rmst_pkg::TREE_LEVELS];
   logic [SPAN_W-1:0]     stk_l_ff [rmst_pkg::TREE_LEVELS];
   logic [SPAN_W-1:0]     stk_r_ff [rmst_pkg::TREE_LEVELS];
   logic                  push_en;
   logic [SP_W-1:0]       top_idx;

   // node geometry
   logic [SPAN_W:0]       span_sum;
   logic [SPAN_W-1:0]     mid;
   logic [NODE_W-1:0]     left_k;
   logic [NODE_W-1:0]     right_k;
   logic [NODE_W-1:0]     sib_k;
   logic [NODE_W-1:0]     parent_k;
   logic                  beyond;
   logic                  sib_beyond;
   logic                  disjoint;
   logic                  covered;

   // shared compare unit
   logic [VALUE_BITS-1:0] min_b;
   logic [VALUE_BITS-1:0] min_y;

   assign span_sum   = {1'b0, l_ff} + {1'b0, r_ff};
   assign mid        = span_sum[SPAN_W:1];
   assign left_k     = {k_ff[NODE_W-2:0], 1'b0};
   assign right_k    = {k_ff[NODE_W-2:0], 1'b1};
   assign sib_k      = {k_ff[NODE_W-1:1], ~k_ff[0]};
   assign parent_k   = {1'b0, k_ff[NODE_W-1:1]};
   assign beyond     = (k_ff >= SLOT_LIM);
   assign sib_beyond = (sib_k >= SLOT_LIM);
   assign disjoint   = (r_ff < lo_ff) || (l_ff > hi_ff);
   assign covered    = (lo_ff <= l_ff) && (r_ff <= hi_ff);
   assign top_idx    = sp_ff - SP_W'(1);

   // second operand: stored node or sentinel for nodes off the tree or range
   assign min_b = opnd_sent_ff ? sentinel : ram_rdata;

   rmst_min_unit #(
      .WIDTH (VALUE_BITS)
   ) u_min (
      .a (acc_ff),
      .b (min_b),
      .y (min_y)
   );

   // state register and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= rmst_pkg::ST_CLEAR;
         clr_ff    <= '0;
         clr_op_ff <= 1'b0;
         fill_ff   <= VALUE_BITS'(rmst_pkg::SENTINEL_RESET);
         sp_ff     <= '0;
         pend_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         clr_op_ff <= clr_op_in;
         fill_ff   <= fill_in;
         sp_ff     <= sp_in;
         pend_ff   <= pend_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pos_ff       <= pos_in;
      val_ff       <= val_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      k_ff         <= k_in;
      l_ff         <= l_in;
      r_ff         <= r_in;
      acc_ff       <= acc_in;
      opnd_sent_ff <= opnd_sent_in;
      if (push_en) begin
         stk_k_ff[sp_ff] <= right_k;
         stk_l_ff[sp_ff] <= mid + SPAN_W'(1);
         stk_r_ff[sp_ff] <= r_ff;
      end
   end

   // next state and outputs
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      val_in       = val_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      k_in         = k_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      acc_in       = acc_ff;
      pend_in      = 1'b0;
      opnd_sent_in = opnd_sent_ff;
      clr_in       = clr_ff;
      clr_op_in    = clr_op_ff;
      fill_in      = fill_ff;
      sp_in        = sp_ff;
      push_en      = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = k_ff[ADDR_W-1:0];
      ram_wdata    = val_ff;
      ram_raddr    = k_ff[ADDR_W-1:0];
      status.ready = 1'b0;
      status.done  = 1'b0;

      unique case (state_ff)
         // sweep the whole store with the fill value
         rmst_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = fill_ff;
            clr_in    = clr_ff + ADDR_W'(1);
            if (clr_ff == LAST_ADDR) begin
               clr_in = '0;
               if (clr_op_ff) begin
                  acc_in   = '0;
                  state_in = rmst_pkg::ST_FINISH;
               end else begin
                  state_in = rmst_pkg::ST_IDLE;
               end
            end
         end

         rmst_pkg::ST_IDLE: begin
            status.ready = 1'b1;
            if (start) begin
               pos_in = SPAN_W'(item.leaf_position);
               val_in = VALUE_BITS'(item.leaf_value);
               lo_in  = SPAN_W'(item.range_low);
               hi_in  = SPAN_W'(item.range_high);
               k_in   = ROOT;
               l_in   = '0;
               r_in   = size - SPAN_W'(1);
               sp_in  = '0;
               unique case (item.func)
                  rmst_pkg::FUNC_QUERY: begin
                     // no leaves or empty range: nothing but the sentinel
                     if ((size == '0) || (item.range_low > item.range_high)) begin
                        acc_in   = sentinel;
                        state_in = rmst_pkg::ST_FINISH;
                     end else begin
                        acc_in   = '1;
                        state_in = rmst_pkg::ST_QWALK;
                     end
                  end
                  rmst_pkg::FUNC_UPDATE: begin
                     acc_in = '0;
                     if ((size == '0) || (SPAN_W'(item.leaf_position) >= size)) begin
                        state_in = rmst_pkg::ST_FINISH;
                     end else begin
                        state_in = rmst_pkg::ST_UDOWN;
                     end
                  end
                  rmst_pkg::FUNC_CLEAR: begin
                     fill_in   = sentinel;
                     clr_in    = '0;
                     clr_op_in = 1'b1;
                     state_in  = rmst_pkg::ST_CLEAR;
                  end
                  default: begin
                     acc_in   = '0;
                     state_in = rmst_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         // one node per cycle; its value joins the minimum from the registered read
         rmst_pkg::ST_QWALK: begin
            if (pend_ff) begin
               acc_in = min_y;
            end
            if (disjoint || covered || beyond) begin
               pend_in      = 1'b1;
               opnd_sent_in = disjoint || beyond;
               if (sp_ff == '0) begin
                  state_in = rmst_pkg::ST_QDRAIN;
               end else begin
                  k_in  = stk_k_ff[top_idx];
                  l_in  = stk_l_ff[top_idx];
                  r_in  = stk_r_ff[top_idx];
                  sp_in = top_idx;
               end
            end else begin
               // split: keep the right half for later, go left
               push_en = 1'b1;
               sp_in   = sp_ff + SP_W'(1);
               k_in    = left_k;
               r_in    = mid;
            end
         end

         rmst_pkg::ST_QDRAIN: begin
            acc_in   = min_y;
            state_in = rmst_pkg::ST_FINISH;
         end

         // descend towards the leaf and write it
         rmst_pkg::ST_UDOWN: begin
            if (beyond || (l_ff == r_ff)) begin
               ram_we = !beyond;
               acc_in = beyond ? sentinel : val_ff;
               if (k_ff == ROOT) begin
                  acc_in   = '0;
                  state_in = rmst_pkg::ST_FINISH;
               end else begin
                  state_in = rmst_pkg::ST_URD;
               end
            end else if (pos_ff <= mid) begin
               k_in = left_k;
               r_in = mid;
            end else begin
               k_in = right_k;
               l_in = mid + SPAN_W'(1);
            end
         end

         // ascent: fetch the sibling of the node just repaired
         rmst_pkg::ST_URD: begin
            ram_raddr    = sib_k[ADDR_W-1:0];
            opnd_sent_in = sib_beyond;
            state_in     = rmst_pkg::ST_UWR;
         end

         // ascent: write the parent's new minimum
         rmst_pkg::ST_UWR: begin
            ram_we    = 1'b1;
            ram_waddr = parent_k[ADDR_W-1:0];
            ram_wdata = min_y;
            acc_in    = min_y;
            k_in      = parent_k;
            if (parent_k == ROOT) begin
               acc_in   = '0;
               state_in = rmst_pkg::ST_FINISH;
            end else begin
               state_in = rmst_pkg::ST_URD;
            end
         end

         rmst_pkg::ST_FINISH: begin
            status.done = 1'b1;
            if (out_free) begin
               clr_op_in = 1'b0;
               state_in  = rmst_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = rmst_pkg::ST_IDLE;
         end
      endcase
   end

   assign result = acc_ff;

   // checks
   a_stack_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_W'(rmst_pkg::TREE_LEVELS))
      else $error("query stack overflow");

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmst_pkg::ST_QWALK || state_ff == rmst_pkg::ST_QDRAIN) |-> !ram_we)
      else $error("store written during a query");

   a_drain_pending: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmst_pkg::ST_QDRAIN) |-> pend_ff)
      else $error("query drain without a pending node");

   a_pend_in_query: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> $past(state_ff == rmst_pkg::ST_QWALK))
      else $error("pending node outside the query walk");

   a_ascent_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rmst_pkg::ST_URD) |=> (state_ff == rmst_pkg::ST_UWR))
      else $error("sibling read not followed by parent write");

endmodule

### src/range_min_segment_tree.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_min_segment_tree
// Segment tree of minima with clear, leaf update and range-minimum query.
// ----------------------------------------------------------------------------
// Use: one request beat on req_* carries an operation in req_tuser (query,
// update, clear) and its operands in req_tdata; every request gives exactly
// one response beat on rsp_* (the minimum for a query, zero otherwise).
// csr_* sets the leaves in use and the sentinel; the user is to write them
// only while the block is idle, which the block itself does not enforce.
// Items are handled one at a time by a sequencer that walks the tree node
// by node over a single-port-write node store; req_tready is high only
// while it waits for work. A query visits at most ~4 nodes per level; an
// update descends to the leaf, then reads the sibling and writes the parent
// at each level on the way up; a clear writes one node per cycle.
// Reset sets the control and configuration registers to their defaults and
// then sweeps the store with the reset sentinel with req_tready low; csr
// writes are taken during the sweep.
// A finished response sits in an output register; a stalled receiver holds
// it there while the next request is accepted and worked on, and that item
// waits with its result until the register frees up.
// ----------------------------------------------------------------------------
module range_min_segment_tree #(
   parameter int LEAF_COUNT = 1024,
   parameter int VALUE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // leaf_position, leaf_value, range_low, range_high
   input  logic [1:0]  req_tuser,   // func
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // minimum
   // configuration writes
   input  logic        csr_we,
   input  logic [rmst_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int SPAN_W = rmst_pkg::SPAN_W;
   localparam int ADDR_W = $clog2(2 * LEAF_COUNT);

   logic [SPAN_W-1:0]          leaves_ff, leaves_in;
   logic [rmst_pkg::DATA_W-1:0] sentinel_ff, sentinel_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [15:0]                rsp_data_ff, rsp_data_in;

   rmst_pkg::req_item_type     item;
   rmst_pkg::seq_status_type   status;
   logic                       start;
   logic                       out_free;
   logic [SPAN_W-1:0]          size;
   logic [VALUE_BITS-1:0]      sentinel_v;
   logic [VALUE_BITS-1:0]      result;

   logic                       ram_we;
   logic [ADDR_W-1:0]          ram_waddr;
   logic [VALUE_BITS-1:0]      ram_wdata;
   logic [ADDR_W-1:0]          ram_raddr;
   logic [VALUE_BITS-1:0]      ram_rdata;

   // unpack the request beat
   assign item.func          = rmst_pkg::func_type'(req_tuser);
   assign item.leaf_position = req_tdata[9:0];
   assign item.leaf_value    = req_tdata[25:10];
   assign item.range_low     = req_tdata[35:26];
   assign item.range_high    = req_tdata[45:36];

   assign req_tready = status.ready;
   assign start      = req_tvalid && status.ready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // leaves in use saturate at the store size
   assign size       = (32'(leaves_ff) > LEAF_COUNT) ? SPAN_W'(LEAF_COUNT) : leaves_ff;
   assign sentinel_v = VALUE_BITS'(sentinel_ff);

   // configuration registers
   always_comb begin
      leaves_in   = leaves_ff;
      sentinel_in = sentinel_ff;
      if (csr_we) begin
         unique case (csr_index)
            rmst_pkg::CSR_LEAVES:   leaves_in   = csr_wdata[SPAN_W-1:0];
            rmst_pkg::CSR_SENTINEL: sentinel_in = csr_wdata;
            default: begin
               leaves_in   = leaves_ff;
               sentinel_in = sentinel_ff;
            end
         endcase
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (status.done && out_free) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = 16'(result);
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         leaves_ff    <= rmst_pkg::LEAVES_RESET;
         sentinel_ff  <= rmst_pkg::SENTINEL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         leaves_ff    <= leaves_in;
         sentinel_ff  <= sentinel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   rmst_seq #(
      .LEAF_COUNT (LEAF_COUNT),
      .VALUE_BITS (VALUE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .item      (item),
      .size      (size),
      .sentinel  (sentinel_v),
      .out_free  (out_free),
      .status    (status),
      .result    (result),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata)
   );

   // node minima, entry 0 unused
   rmst_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (2 * LEAF_COUNT)
   ) u_nodes (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

endmodule
